[rtl/emprg_pkg.sv]
// constants, types and power application function for the encoder motor power regulator
package emprg_pkg;

  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 16;

  localparam logic [CfgAddrW-1:0] REG_MODE       = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_CHECK_IVL  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_TARGET_PPS = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_TARGET_POS = 2'd3;

  localparam logic        MODE_RATE        = 1'b0;
  localparam logic        MODE_TARGET      = 1'b1;
  localparam logic [15:0] CHECK_IVL_RESET  = 16'd100;
  localparam logic [31:0] RATE_IVL_MS      = 32'd20;
  localparam logic signed [15:0] STALL_STEP = 16'sd5;
  localparam logic signed [15:0] P16_MAX   = 16'sh7fff;
  localparam logic signed [15:0] P16_MIN   = -16'sh8000;
  localparam logic signed [15:0] DUTY_MAX  = 16'sd255;

  // 2^23 / 50 rounded up, exact truncation for magnitudes up to 2^17
  localparam logic [17:0] RECIP_50  = 18'd167773;
  localparam int unsigned RECIP_SH  = 23;
  localparam int unsigned WantW     = 13;

  typedef struct packed {
    logic [7:0] duty;
    logic       in1;
    logic       in2;
    logic       active;
  } drive_t;

  typedef struct packed {
    drive_t drive;
    logic   rejected;
  } apply_t;

  function automatic apply_t apply_power(input logic signed [15:0] p, input drive_t held);
    apply_t           r;
    logic signed [16:0] m;
    begin
      m = -{p[15], p};
      r.drive    = held;
      r.rejected = 1'b0;
      if (p > DUTY_MAX) begin
        r.rejected = 1'b1;
      end else if (p > 16'sd0) begin
        r.drive.duty   = p[7:0];
        r.drive.in1    = 1'b0;
        r.drive.in2    = 1'b1;
        r.drive.active = 1'b1;
      end else begin
        r.drive.duty   = (m > 17'sd255) ? 8'd255 : m[7:0];
        r.drive.in1    = 1'b1;
        r.drive.in2    = 1'b0;
        r.drive.active = 1'b0;
      end
      apply_power = r;
    end
  endfunction

endpackage

[rtl/encoder_motor_power_regulator.sv]
// encoder motor power regulator: one control call per word, rate or position target mode
// Usage: each input word is one control call carrying the millisecond time and the
// encoder position. Each call gives exactly one result word with the held pwm duty,
// the two bridge direction lines, the active flag and a rejected-power flag.
// Configuration (mode, stall check interval, target pulse rate, target position) must be
// written by the user through cfg_wr_en/cfg_addr/cfg_wdata while no word is in flight;
// the block itself does not enforce this. Pipeline: an input register and a result
// register with the state update between them. While out_tready stays high one word is
// taken every cycle, a rate set by the single compare-and-step pass on registered state.
// The target pulse rate is scaled to counts per 20 ms when the register is written.
// When the receiver stalls the result register holds and the input register fills,
// after which in_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) clears both stages, the timing and power state,
// stops the motor and restores the register defaults.
module encoder_motor_power_regulator
  import emprg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // now_ms[31:0], position[63:32]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // pwm_duty, dir_in1, dir_in2, motor_active, power_rejected
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic                    mode_r;
  logic [15:0]             chk_ivl_r;
  logic signed [WantW-1:0] want_r, want_nxt;
  logic signed [31:0]      tgt_pos_r;

  // pipeline
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_now_r;
  logic [31:0] s1_pos_r;
  logic        out_valid_r, out_valid_nxt;
  logic        adv, in_acc;

  // state
  logic [31:0]        last_chk_r, last_chk_nxt;
  logic [31:0]        last_cnt_r, last_cnt_nxt;
  logic signed [15:0] rate_pwr_r, rate_pwr_nxt;
  logic signed [15:0] stall_pwr_r, stall_pwr_nxt;
  drive_t             held_r, held_nxt;
  logic               rej_r, rej_nxt;

  // datapath
  logic [17:0]        tr_mag;
  logic [35:0]        tr_prod;
  logic [WantW-1:0]   tr_q;
  logic [31:0]        elapsed;
  logic signed [31:0] pulses;
  logic signed [31:0] want_ext;
  logic signed [16:0] stall_sum;
  logic signed [15:0] stall_inc;
  logic signed [15:0] rate_inc, rate_dec;
  apply_t             ap_rate_inc, ap_rate_dec, ap_stall;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // target pps scaled to counts per 20 ms, truncated toward zero
  assign tr_mag   = cfg_wdata[17] ? (18'd0 - cfg_wdata[17:0]) : cfg_wdata[17:0];
  assign tr_prod  = tr_mag * RECIP_50;
  assign tr_q     = tr_prod[RECIP_SH +: WantW];
  assign want_nxt = cfg_wdata[17] ? -$signed(tr_q) : $signed(tr_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RATE;
      chk_ivl_r <= CHECK_IVL_RESET;
      want_r    <= '0;
      tgt_pos_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MODE:       mode_r    <= cfg_wdata[0];
        REG_CHECK_IVL:  chk_ivl_r <= cfg_wdata[15:0];
        REG_TARGET_PPS: want_r    <= want_nxt;
        REG_TARGET_POS: tgt_pos_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign elapsed   = s1_now_r - last_chk_r;
  assign pulses    = $signed(s1_pos_r - last_cnt_r);
  assign want_ext  = 32'(want_r);
  assign rate_inc  = (rate_pwr_r == P16_MAX) ? rate_pwr_r : rate_pwr_r + 16'sd1;
  assign rate_dec  = (rate_pwr_r == P16_MIN) ? rate_pwr_r : rate_pwr_r - 16'sd1;
  assign stall_sum = 17'(stall_pwr_r) + 17'(STALL_STEP);
  assign stall_inc = (stall_sum > 17'sd32767) ? P16_MAX : stall_sum[15:0];

  always_comb begin
    last_chk_nxt  = last_chk_r;
    last_cnt_nxt  = last_cnt_r;
    rate_pwr_nxt  = rate_pwr_r;
    stall_pwr_nxt = stall_pwr_r;
    held_nxt      = held_r;
    rej_nxt       = 1'b0;
    ap_rate_inc   = apply_power(rate_inc, held_r);
    ap_rate_dec   = apply_power(rate_dec, held_r);
    ap_stall      = apply_power(stall_pwr_r, held_r);
    if (mode_r == MODE_RATE) begin
      if (elapsed >= RATE_IVL_MS) begin
        last_chk_nxt = s1_now_r;
        last_cnt_nxt = s1_pos_r;
        if (pulses < want_ext) begin
          rate_pwr_nxt = rate_inc;
          held_nxt     = ap_rate_inc.drive;
          rej_nxt      = ap_rate_inc.rejected;
        end else if (pulses > want_ext) begin
          rate_pwr_nxt = rate_dec;
          held_nxt     = ap_rate_dec.drive;
          rej_nxt      = ap_rate_dec.rejected;
        end
      end
    end else begin
      if ($signed(s1_pos_r) < tgt_pos_r) begin
        if (elapsed >= {16'd0, chk_ivl_r}) begin
          last_chk_nxt = s1_now_r;
          if (s1_pos_r != last_cnt_r) begin
            last_cnt_nxt = s1_pos_r;
          end else begin
            stall_pwr_nxt = stall_inc;
          end
        end
        // stall power applied is the value after this check
        ap_stall = apply_power(stall_pwr_nxt, held_r);
        held_nxt = ap_stall.drive;
        rej_nxt  = ap_stall.rejected;
      end else begin
        held_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_chk_r  <= '0;
      last_cnt_r  <= '0;
      rate_pwr_r  <= '0;
      stall_pwr_r <= '0;
      held_r      <= '0;
      rej_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        last_chk_r  <= last_chk_nxt;
        last_cnt_r  <= last_cnt_nxt;
        rate_pwr_r  <= rate_pwr_nxt;
        stall_pwr_r <= stall_pwr_nxt;
        held_r      <= held_nxt;
        rej_r       <= rej_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r <= in_tdata[31:0];
      s1_pos_r <= in_tdata[63:32];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, rej_r, held_r.active, held_r.in2, held_r.in1, held_r.duty};

  // a rejected power leaves the drive untouched
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rej_nxt) |=> $stable(held_r))
    else $error("drive changed on rejected power");

  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(held_r.in1 && held_r.in2))
    else $error("both bridge lines high");

  a_active_dir: assert property (@(posedge clk) disable iff (!rst_n)
    held_r.active |-> (held_r.in2 && !held_r.in1 && (held_r.duty != 8'd0)))
    else $error("active flag without forward drive");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_now_r) && $stable(s1_pos_r)))
    else $error("pending word lost in input stage");

endmodule
